// ===== hw/rtl/prefix_code_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// prefix_code_decoder_defines
// assertion macros shared by the prefix code decoder rtl
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_DECODER_DEFINES_SVH
`define PREFIX_CODE_DECODER_DEFINES_SVH

// same-cycle implication, clocked on clk and disabled in reset
`define PCD_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, clocked on clk and disabled in reset
`define PCD_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/pcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcd_pkg
// shared constants and types of the prefix code decoder
// ----------------------------------------------------------------------------
package pcd_pkg;

    // table geometry
    localparam int TABLE_DEPTH  = 256;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = IDX_W + 1;

    // codeword geometry
    localparam int MAX_CODE_LEN = 32;
    localparam int HELD_W       = $clog2(MAX_CODE_LEN + 1);
    localparam int BUF_IDX_W    = $clog2(MAX_CODE_LEN);

    // fixed field widths
    localparam int SYM_W        = 8;
    localparam int LEN_W        = 6;
    localparam int CODE_W       = 32;
    localparam int CFG_W        = 9;

    // item operation codes
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_BIT     = 1'b1;

    // one stored table entry
    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
    } entry_t;

    // table write request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
    } wr_req_t;

    // table read request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } rd_req_t;

endpackage

// ===== hw/rtl/pcd_interfaces.sv =====
// ----------------------------------------------------------------------------
// pcd_interfaces
// valid/ready channels of the prefix code decoder
// ----------------------------------------------------------------------------

// input item channel
interface pcd_item_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [7:0]                     entry_index;
    logic [pcd_pkg::SYM_W-1:0]      entry_symbol;
    logic [pcd_pkg::LEN_W-1:0]      entry_length;
    logic [pcd_pkg::CODE_W-1:0]     entry_code;
    logic                           code_bit;

    modport source (output valid, operation, entry_index, entry_symbol, entry_length,
                    entry_code, code_bit, input ready);
    modport sink   (input valid, operation, entry_index, entry_symbol, entry_length,
                    entry_code, code_bit, output ready);
endinterface

// result item channel
interface pcd_result_if;
    logic                       valid;
    logic                       ready;
    logic [pcd_pkg::SYM_W-1:0]  decoded_symbol;
    logic                       error_flag;

    modport source (output valid, decoded_symbol, error_flag, input ready);
    modport sink   (input valid, decoded_symbol, error_flag, output ready);
endinterface

// register write channel
interface pcd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [pcd_pkg::CFG_W-1:0]  entries_in_use;

    modport source (output valid, entries_in_use, input ready);
    modport sink   (input valid, entries_in_use, output ready);
endinterface

// ===== hw/rtl/pcd_table.sv =====
// ----------------------------------------------------------------------------
// pcd_table
// code table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module pcd_table (
    input  logic              clk,
    input  pcd_pkg::wr_req_t  wr,
    input  pcd_pkg::rd_req_t  rd,
    output pcd_pkg::entry_t   rd_data
);

    pcd_pkg::entry_t mem [pcd_pkg::TABLE_DEPTH];
    pcd_pkg::entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.entry;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/pcd_match.sv =====
// ----------------------------------------------------------------------------
// pcd_match
// shared compare unit: tests one table entry against the bit buffer
// ----------------------------------------------------------------------------
module pcd_match (
    input  pcd_pkg::entry_t                 entry,
    input  logic [pcd_pkg::CODE_W-1:0]      bit_buf,
    input  logic [pcd_pkg::HELD_W-1:0]      held,
    output logic                            hit
);

    logic [pcd_pkg::CODE_W-1:0] mask;
    logic                       len_ok;
    logic                       bits_ok;

    // low mask of the buffered bits
    always_comb
    begin
        for (int k = 0; k < pcd_pkg::CODE_W; k++)
        begin
            mask[k] = (pcd_pkg::HELD_W'(k) < held);
        end
    end

    // zero-length entries never match
    assign len_ok  = (entry.length != '0) &&
                     (pcd_pkg::HELD_W'(entry.length) == held);
    assign bits_ok = (((entry.code ^ bit_buf) & mask) == '0);
    assign hit     = len_ok && bits_ok;

endmodule

// ===== hw/rtl/prefix_code_decoder.sv =====
// ----------------------------------------------------------------------------
// prefix_code_decoder
// decodes a bit stream against a loaded prefix code table
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  items    | in  | valid/ready   | operation, entry_index, entry_symbol,
//           |     |               | entry_length, entry_code, code_bit
//  results  | out | valid/ready   | decoded_symbol, error_flag
//  cfg      | in  | valid/ready   | entries_in_use (always ready)
//
//  a table-write item is written as it is accepted and leaves the block ready
//  a bit item holds the block while it scans up to min(entries_in_use, 256) table
//  entries, one entry per cycle through the single memory read port and compare
//  unit; the scan stops early at the first match
//  a result waits in an output register until taken; no item is taken meanwhile
//  reset clears the bit buffer, bit count and register; the table is undefined
//  until written
// ----------------------------------------------------------------------------
`include "prefix_code_decoder_defines.svh"

module prefix_code_decoder (
    input  logic        clk,
    input  logic        rst_n,
    pcd_item_if.sink    items,
    pcd_result_if.source results,
    pcd_cfg_if.sink     cfg
);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]                        state_reg,   state_next;
    logic [pcd_pkg::HELD_W-1:0]        held_reg,    held_next;
    logic [pcd_pkg::CODE_W-1:0]        buf_reg,     buf_next;
    logic [pcd_pkg::CFG_W-1:0]         eiu_reg;
    logic [pcd_pkg::CNT_W-1:0]         issue_reg,   issue_next;
    logic                              pending_reg, pending_next;
    logic [pcd_pkg::SYM_W-1:0]         sym_reg,     sym_next;
    logic                              err_reg,     err_next;

    logic [pcd_pkg::CNT_W-1:0]         limit;
    logic                              item_fire;
    logic                              hit;
    pcd_pkg::wr_req_t                  wr;
    pcd_pkg::rd_req_t                  rd;
    pcd_pkg::entry_t                   rd_data;

    // handshakes
    assign items.ready     = (state_reg == ST_IDLE);
    assign item_fire       = items.valid && items.ready;
    assign cfg.ready       = 1'b1;
    assign results.valid   = (state_reg == ST_OUT);
    assign results.decoded_symbol = sym_reg;
    assign results.error_flag     = err_reg;

    // search limit clamped to the table depth
    assign limit = (pcd_pkg::CNT_W'(eiu_reg) > pcd_pkg::CNT_W'(pcd_pkg::TABLE_DEPTH))
                   ? pcd_pkg::CNT_W'(pcd_pkg::TABLE_DEPTH)
                   : pcd_pkg::CNT_W'(eiu_reg);

    // table write straight from the item
    always_comb
    begin
        wr.en           = item_fire && (items.operation == pcd_pkg::OP_WRITE);
        wr.idx          = items.entry_index[pcd_pkg::IDX_W-1:0];
        wr.entry.symbol = items.entry_symbol;
        wr.entry.length = items.entry_length;
        wr.entry.code   = items.entry_code;
    end

    // table read during the scan
    assign rd.en  = (state_reg == ST_SCAN) && (issue_reg < limit);
    assign rd.idx = issue_reg[pcd_pkg::IDX_W-1:0];

    pcd_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    pcd_match u_match (
        .entry   (rd_data),
        .bit_buf (buf_reg),
        .held    (held_reg),
        .hit     (hit)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        held_next    = held_reg;
        buf_next     = buf_reg;
        issue_next   = issue_reg;
        pending_next = pending_reg;
        sym_next     = sym_reg;
        err_next     = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // append the bit and start a scan from entry zero
                if (item_fire && (items.operation == pcd_pkg::OP_BIT))
                begin
                    buf_next[held_reg[pcd_pkg::BUF_IDX_W-1:0]] = items.code_bit;
                    held_next    = held_reg + pcd_pkg::HELD_W'(1);
                    issue_next   = '0;
                    pending_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd.en)
                begin
                    issue_next = issue_reg + pcd_pkg::CNT_W'(1);
                end
                pending_next = rd.en;
                if (pending_reg && hit)
                begin
                    // lowest-indexed match wins
                    sym_next     = rd_data.symbol;
                    err_next     = 1'b0;
                    held_next    = '0;
                    buf_next     = '0;
                    pending_next = 1'b0;
                    state_next   = ST_OUT;
                end
                else if (!rd.en && !pending_reg)
                begin
                    // scan done without a match
                    if (held_reg == pcd_pkg::HELD_W'(pcd_pkg::MAX_CODE_LEN))
                    begin
                        sym_next   = '0;
                        err_next   = 1'b1;
                        held_next  = '0;
                        buf_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT:
            begin
                if (results.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            held_reg    <= '0;
            buf_reg     <= '0;
            eiu_reg     <= '0;
            issue_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            buf_reg     <= buf_next;
            issue_reg   <= issue_next;
            pending_reg <= pending_next;
            if (cfg.valid && cfg.ready)
            begin
                eiu_reg <= cfg.entries_in_use;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
        err_reg <= err_next;
    end

    // checks
    `PCD_ASSERT_IMP(a_held_bound, 1'b1, held_reg <= pcd_pkg::HELD_W'(pcd_pkg::MAX_CODE_LEN), "bit count above maximum code length")
    `PCD_ASSERT_IMP(a_err_sym_zero, results.valid && results.error_flag, results.decoded_symbol == '0, "error result with nonzero symbol")
    `PCD_ASSERT_NXT(a_bit_starts_scan, item_fire && (items.operation == pcd_pkg::OP_BIT), (state_reg == ST_SCAN) && (issue_reg == '0), "bit item did not start a scan")
    `PCD_ASSERT_IMP(a_issue_bound, state_reg == ST_SCAN, issue_reg <= limit, "scan pointer beyond search limit")
    `PCD_ASSERT_NXT(a_result_clears, (state_reg == ST_SCAN) && (state_next == ST_OUT), held_reg == '0 && buf_reg == '0, "buffer not cleared on result")

endmodule
